### hw/rtl/lpps_pkg.sv
// Shared constants, types and helper functions for the line position PID steering block.
// Has no dependencies. Every other file in hw/rtl uses it.
`default_nettype none
package lpps_pkg;

   // Sensor array and sample format
   localparam int SENSOR_COUNT = 8;
   localparam int SAMPLE_W     = 12;
   localparam int CH_W         = $clog2(SENSOR_COUNT);
   localparam logic [SAMPLE_W-1:0] RESET_LOW  = SAMPLE_W'(2500);
   localparam logic [SAMPLE_W-1:0] RESET_HIGH = SAMPLE_W'(4095);

   // Calibration scale and centroid weights
   localparam int CAL_SCALE    = 1000;
   localparam int WEIGHT_PITCH = 1000;
   localparam int CAL_W        = $clog2(CAL_SCALE + 1);
   localparam int MAX_WT       = ((SENSOR_COUNT - 1) * WEIGHT_PITCH) / 2;
   localparam int WT_W         = $clog2(MAX_WT + 1) + 1;
   localparam int PROD_W       = CAL_W + 1 + WT_W;
   localparam int TOTAL_W      = $clog2(SENSOR_COUNT * CAL_SCALE + 1);
   localparam int WMAG_W       = $clog2(SENSOR_COUNT * CAL_SCALE * MAX_WT + 1);
   localparam int WSUM_W       = WMAG_W + 1;
   localparam int SNUM_W       = $clog2(((2 ** SAMPLE_W) - 1) * CAL_SCALE + 1);

   // Shared serial divider sizes
   localparam int DIV_NUM_W = (WMAG_W > SNUM_W) ? WMAG_W : SNUM_W;
   localparam int DIV_DEN_W = (TOTAL_W > SAMPLE_W) ? TOTAL_W : SAMPLE_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // Position and PID formats
   localparam int POS_W          = 13;
   localparam int ESUM_W         = 32;
   localparam int GAIN_W         = 12;
   localparam int SPEED_W        = 8;
   localparam int GAIN_FRAC_BITS = 10;
   localparam int DUTY_MAX       = 255;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] REG_KP   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_KI   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_KD   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_BASE = CSR_IDX_W'(3);
   localparam logic [GAIN_W-1:0]  KP_RESET   = GAIN_W'(512);
   localparam logic [GAIN_W-1:0]  KI_RESET   = GAIN_W'(0);
   localparam logic [GAIN_W-1:0]  KD_RESET   = GAIN_W'(102);
   localparam logic [SPEED_W-1:0] BASE_RESET = SPEED_W'(150);

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Centroid weight of one channel, truncated toward zero
   function automatic logic signed [WT_W-1:0] chan_weight(input logic [CH_W-1:0] ch);
      int off;
      off = 2 * int'(ch) - (SENSOR_COUNT - 1);
      return WT_W'((off * WEIGHT_PITCH) / 2);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lpps_if.sv
// Valid/ready channel interfaces: scan input, steering result and register writes.
// Depends on lpps_pkg for field widths.
`default_nettype none
interface lpps_req_if;
   logic valid;
   logic ready;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_0;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_1;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_2;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_3;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_4;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_5;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_6;
   logic [lpps_pkg::SAMPLE_W-1:0] sample_7;
   modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, input ready);
   modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface lpps_rsp_if;
   logic valid;
   logic ready;
   logic signed [lpps_pkg::POS_W-1:0] line_position;
   logic [lpps_pkg::SPEED_W-1:0]      left_speed;
   logic [lpps_pkg::SPEED_W-1:0]      right_speed;
   modport source (output valid, line_position, left_speed, right_speed, input ready);
   modport sink   (input valid, line_position, left_speed, right_speed, output ready);
endinterface

interface lpps_csr_if;
   logic valid;
   logic ready;
   logic [lpps_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [lpps_pkg::CSR_DATA_W-1:0] wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

### hw/rtl/lpps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lpps_pkg for operand widths and the status struct.
`default_nettype none
module lpps_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lpps_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [lpps_pkg::DIV_DEN_W-1:0] den,
   output lpps_pkg::div_stat_type             stat,
   output logic [lpps_pkg::DIV_NUM_W-1:0]      quo
);
   localparam int NW = lpps_pkg::DIV_NUM_W;
   localparam int DW = lpps_pkg::DIV_DEN_W;
   localparam int CW = lpps_pkg::DIV_CNT_W;

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[NW-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;
endmodule
`default_nettype wire

### hw/rtl/lpps_pid.sv
// PID step: saturating integral, derivative, three registered gain products, duty clamp.
// Depends on lpps_pkg for formats. Holds previous error and integral state.
`default_nettype none
module lpps_pid (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [lpps_pkg::POS_W-1:0]  pos,
   input  wire logic [lpps_pkg::GAIN_W-1:0]        kp,
   input  wire logic [lpps_pkg::GAIN_W-1:0]        ki,
   input  wire logic [lpps_pkg::GAIN_W-1:0]        kd,
   input  wire logic [lpps_pkg::SPEED_W-1:0]       base,
   output logic                                    done,
   output logic [lpps_pkg::SPEED_W-1:0]            left,
   output logic [lpps_pkg::SPEED_W-1:0]            right
);
   localparam int PW  = lpps_pkg::POS_W;
   localparam int EW  = lpps_pkg::ESUM_W;
   localparam int GW  = lpps_pkg::GAIN_W;
   localparam int SPW = lpps_pkg::SPEED_W;
   localparam int F   = lpps_pkg::GAIN_FRAC_BITS;
   localparam int DRW = PW + 1;
   localparam int PPW = GW + 1 + PW;
   localparam int PIW = GW + 1 + EW;
   localparam int PDW = GW + 1 + DRW;
   localparam int SW  = PIW + 2;
   localparam int VW  = SW + 1;
   localparam logic signed [VW-1:0] DUTY_TOP = VW'(lpps_pkg::DUTY_MAX * (2 ** F));
   localparam logic signed [EW-1:0] ESUM_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] ESUM_MIN = {1'b1, {(EW-1){1'b0}}};

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_MP   = 3'd1;
   localparam logic [2:0] P_MI   = 3'd2;
   localparam logic [2:0] P_MD   = 3'd3;
   localparam logic [2:0] P_SUM  = 3'd4;
   localparam logic [2:0] P_OUT  = 3'd5;

   // Clamp a fixed-point duty to 0..DUTY_MAX, then drop the fraction
   function automatic logic [SPW-1:0] duty(input logic signed [VW-1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > DUTY_TOP) begin
         return SPW'(lpps_pkg::DUTY_MAX);
      end else begin
         return v[F +: SPW];
      end
   endfunction

   logic [2:0]               state_ff, state_in;
   logic signed [PW-1:0]     err_ff, err_in;
   logic signed [PW-1:0]     prev_ff, prev_in;
   logic signed [EW-1:0]     esum_ff, esum_in;
   logic signed [DRW-1:0]    der_ff, der_in;
   logic signed [PPW-1:0]    pp_ff, pp_in;
   logic signed [PIW-1:0]    pi_ff, pi_in;
   logic signed [PDW-1:0]    pd_ff, pd_in;
   logic signed [SW-1:0]     s_ff, s_in;
   logic [SPW-1:0]           left_ff, left_in;
   logic [SPW-1:0]           right_ff, right_in;
   logic                     done_ff, done_in;
   logic signed [EW:0]       esum_wide;
   logic signed [VW-1:0]     base_fx;

   assign esum_wide = (EW+1)'(esum_ff) + (EW+1)'(pos);
   assign base_fx   = $signed(VW'({base, {F{1'b0}}}));

   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      prev_in  = prev_ff;
      esum_in  = esum_ff;
      der_in   = der_ff;
      pp_in    = pp_ff;
      pi_in    = pi_ff;
      pd_in    = pd_ff;
      s_in     = s_ff;
      left_in  = left_ff;
      right_in = right_ff;
      done_in  = 1'b0;
      case (state_ff)
         P_IDLE: begin
            // Update integral with saturation, take derivative, remember error
            if (start) begin
               err_in  = pos;
               prev_in = pos;
               der_in  = DRW'(pos) - DRW'(prev_ff);
               if (esum_wide[EW] != esum_wide[EW-1]) begin
                  esum_in = esum_wide[EW] ? ESUM_MIN : ESUM_MAX;
               end else begin
                  esum_in = esum_wide[EW-1:0];
               end
               state_in = P_MP;
            end
         end
         P_MP: begin
            pp_in    = $signed({1'b0, kp}) * err_ff;
            state_in = P_MI;
         end
         P_MI: begin
            pi_in    = $signed({1'b0, ki}) * esum_ff;
            state_in = P_MD;
         end
         P_MD: begin
            pd_in    = $signed({1'b0, kd}) * der_ff;
            state_in = P_SUM;
         end
         P_SUM: begin
            s_in     = SW'(pp_ff) + SW'(pi_ff) + SW'(pd_ff);
            state_in = P_OUT;
         end
         P_OUT: begin
            left_in  = duty(base_fx - VW'(s_ff));
            right_in = duty(base_fx + VW'(s_ff));
            done_in  = 1'b1;
            state_in = P_IDLE;
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      der_ff   <= der_in;
      pp_ff    <= pp_in;
      pi_ff    <= pi_in;
      pd_ff    <= pd_in;
      s_ff     <= s_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      if (reset) begin
         state_ff <= P_IDLE;
         prev_ff  <= '0;
         esum_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         esum_ff  <= esum_in;
         done_ff  <= done_in;
      end
   end

   assign done  = done_ff;
   assign left  = left_ff;
   assign right = right_ff;
endmodule
`default_nettype wire

### hw/rtl/line_position_pid_steering.sv
// Line position PID steering: top level with the channel sequencer and output register.
// Depends on lpps_pkg, the interfaces in lpps_if, lpps_div and lpps_pid.
//
// Usage:
//   req_ch carries one scan of eight 12-bit samples; rsp_ch returns one item per scan
//   with the line position and the left and right motor duties. csr_ch writes the
//   gains and base speed (index 0 kp, 1 ki, 2 kd, 3 base); it is always ready and
//   should be written only while no scan is in flight. Unknown indexes are dropped.
//   One scan is worked at a time. For each channel the min/max marks update, the
//   sample is scaled by a 25-step bit-serial divide and weighted into the centroid
//   (a flat channel skips its divide); the centroid takes one more divide, then the
//   PID step runs. The block is ready for the next scan once the result enters the
//   output register. The shared serial divider (at most nine divisions per scan)
//   takes most of the time of each scan.
//   If rsp_ch stalls, the finished result holds in the output register; a following
//   scan may still be accepted and worked, and waits for the register to free.
//   Reset (synchronous) restores the register defaults, marks (low 2500, high 4095),
//   integral and previous error to zero, and empties the output register.
`default_nettype none
module line_position_pid_steering (
   input  wire logic clock,
   input  wire logic reset,
   lpps_req_if.sink   req_ch,
   lpps_rsp_if.source rsp_ch,
   lpps_csr_if.sink   csr_ch
);
   localparam int N   = lpps_pkg::SENSOR_COUNT;
   localparam int SW  = lpps_pkg::SAMPLE_W;
   localparam int CHW = lpps_pkg::CH_W;
   localparam int CW  = lpps_pkg::CAL_W;
   localparam int NW  = lpps_pkg::DIV_NUM_W;
   localparam int DW  = lpps_pkg::DIV_DEN_W;
   localparam int PW  = lpps_pkg::POS_W;
   localparam int TW  = lpps_pkg::TOTAL_W;
   localparam int WW  = lpps_pkg::WSUM_W;
   localparam int PRW = lpps_pkg::PROD_W;
   localparam int GW  = lpps_pkg::GAIN_W;
   localparam int SPW = lpps_pkg::SPEED_W;
   localparam int SNW = lpps_pkg::SNUM_W;
   localparam logic [NW-1:0] POS_HI_MAG = NW'((2 ** (PW - 1)) - 1);
   localparam logic [NW-1:0] POS_LO_MAG = NW'(2 ** (PW - 1));
   localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MARK   = 4'd1;
   localparam logic [3:0] ST_SCALE  = 4'd2;
   localparam logic [3:0] ST_SDIV   = 4'd3;
   localparam logic [3:0] ST_ACC    = 4'd4;
   localparam logic [3:0] ST_SUM    = 4'd5;
   localparam logic [3:0] ST_CENT   = 4'd6;
   localparam logic [3:0] ST_CDIV   = 4'd7;
   localparam logic [3:0] ST_PSTART = 4'd8;
   localparam logic [3:0] ST_PWAIT  = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0]             state_ff, state_in;
   logic [CHW-1:0]         ch_ff, ch_in;
   logic [SW-1:0]          smp_ff [N];
   logic [SW-1:0]          smp_in [N];
   logic [SW-1:0]          low_ff [N];
   logic [SW-1:0]          low_in [N];
   logic [SW-1:0]          high_ff [N];
   logic [SW-1:0]          high_in [N];
   logic [CW-1:0]          cal_ff, cal_in;
   logic signed [PRW-1:0]  prod_ff, prod_in;
   logic signed [WW-1:0]   wsum_ff, wsum_in;
   logic [TW-1:0]          total_ff, total_in;
   logic                   neg_ff, neg_in;
   logic signed [PW-1:0]   pos_ff, pos_in;
   logic [GW-1:0]          kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [SPW-1:0]         base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [PW-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [SPW-1:0]         rsp_left_ff, rsp_left_in;
   logic [SPW-1:0]         rsp_right_ff, rsp_right_in;

   logic [SW-1:0]          cur_raw, cur_low, cur_high, cur_diff;
   logic [SNW-1:0]         scale_num;
   logic [WW-1:0]          wsum_mag;
   logic                   div_start;
   logic [NW-1:0]          div_num;
   logic [DW-1:0]          div_den;
   logic [NW-1:0]          div_quo;
   lpps_pkg::div_stat_type div_stat;
   logic                   pid_start, pid_done;
   logic [SPW-1:0]         pid_left, pid_right;

   // Current channel operands
   assign cur_raw   = smp_ff[ch_ff];
   assign cur_low   = low_ff[ch_ff];
   assign cur_high  = high_ff[ch_ff];
   assign cur_diff  = cur_high - cur_low;
   assign scale_num = SNW'(cur_raw - cur_low) * SNW'(lpps_pkg::CAL_SCALE);
   assign wsum_mag  = wsum_ff[WW-1] ? WW'(-wsum_ff) : WW'(wsum_ff);

   // Divider operands: calibration divide or centroid divide
   always_comb begin
      if (state_ff == ST_SCALE) begin
         div_num = NW'(scale_num);
         div_den = DW'(cur_diff);
      end else begin
         div_num = NW'(wsum_mag);
         div_den = DW'(total_ff);
      end
   end

   lpps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   lpps_pid u_pid (
      .clock (clock),
      .reset (reset),
      .start (pid_start),
      .pos   (pos_ff),
      .kp    (kp_ff),
      .ki    (ki_ff),
      .kd    (kd_ff),
      .base  (base_ff),
      .done  (pid_done),
      .left  (pid_left),
      .right (pid_right)
   );

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      cal_in       = cal_ff;
      prod_in      = prod_ff;
      wsum_in      = wsum_ff;
      total_in     = total_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      div_start    = 1'b0;
      pid_start    = 1'b0;

      // Register writes
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            lpps_pkg::REG_KP:   kp_in   = csr_ch.wr_data[GW-1:0];
            lpps_pkg::REG_KI:   ki_in   = csr_ch.wr_data[GW-1:0];
            lpps_pkg::REG_KD:   kd_in   = csr_ch.wr_data[GW-1:0];
            lpps_pkg::REG_BASE: base_in = csr_ch.wr_data[SPW-1:0];
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               smp_in[0] = req_ch.sample_0;
               smp_in[1] = req_ch.sample_1;
               smp_in[2] = req_ch.sample_2;
               smp_in[3] = req_ch.sample_3;
               smp_in[4] = req_ch.sample_4;
               smp_in[5] = req_ch.sample_5;
               smp_in[6] = req_ch.sample_6;
               smp_in[7] = req_ch.sample_7;
               ch_in     = '0;
               wsum_in   = '0;
               total_in  = '0;
               state_in  = ST_MARK;
            end
         end
         ST_MARK: begin
            // Widen the running marks to take in this sample
            if (cur_raw < cur_low) begin
               low_in[ch_ff] = cur_raw;
            end
            if (cur_raw > cur_high) begin
               high_in[ch_ff] = cur_raw;
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // Flat channel scales to zero
            if (cur_diff == '0) begin
               cal_in   = '0;
               state_in = ST_ACC;
            end else begin
               div_start = 1'b1;
               state_in  = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (div_stat.done) begin
               if (div_quo > NW'(lpps_pkg::CAL_SCALE)) begin
                  cal_in = CW'(lpps_pkg::CAL_SCALE);
               end else begin
                  cal_in = div_quo[CW-1:0];
               end
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            prod_in  = $signed({1'b0, cal_ff}) * lpps_pkg::chan_weight(ch_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Accumulate and advance to the next channel
            wsum_in  = wsum_ff + WW'(prod_ff);
            total_in = total_ff + TW'(cal_ff);
            if (ch_ff == CHW'(N - 1)) begin
               state_in = ST_CENT;
            end else begin
               ch_in    = ch_ff + CHW'(1);
               state_in = ST_MARK;
            end
         end
         ST_CENT: begin
            // Dark scan gives position zero
            if (total_ff == '0) begin
               pos_in   = '0;
               state_in = ST_PSTART;
            end else begin
               neg_in    = wsum_ff[WW-1];
               div_start = 1'b1;
               state_in  = ST_CDIV;
            end
         end
         ST_CDIV: begin
            // Restore sign, saturate to the position field
            if (div_stat.done) begin
               if (neg_ff) begin
                  if (div_quo > POS_LO_MAG) begin
                     pos_in = POS_MIN;
                  end else begin
                     pos_in = -$signed(div_quo[PW-1:0]);
                  end
               end else begin
                  if (div_quo > POS_HI_MAG) begin
                     pos_in = POS_MAX;
                  end else begin
                     pos_in = $signed(div_quo[PW-1:0]);
                  end
               end
               state_in = ST_PSTART;
            end
         end
         ST_PSTART: begin
            pid_start = 1'b1;
            state_in  = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (pid_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_left_in  = pid_left;
               rsp_right_in = pid_right;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      smp_ff       <= smp_in;
      cal_ff       <= cal_in;
      prod_ff      <= prod_in;
      wsum_ff      <= wsum_in;
      total_ff     <= total_in;
      neg_ff       <= neg_in;
      pos_ff       <= pos_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         kp_ff        <= lpps_pkg::KP_RESET;
         ki_ff        <= lpps_pkg::KI_RESET;
         kd_ff        <= lpps_pkg::KD_RESET;
         base_ff      <= lpps_pkg::BASE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            low_ff[i]  <= lpps_pkg::RESET_LOW;
            high_ff[i] <= lpps_pkg::RESET_HIGH;
         end
      end else begin
         state_ff     <= state_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.line_position = rsp_pos_ff;
   assign rsp_ch.left_speed    = rsp_left_ff;
   assign rsp_ch.right_speed   = rsp_right_ff;

   // A new result appears only from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result appeared outside the output step");

   // Marks never cross once updated
   a_marks_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> (cur_low <= cur_high))
      else $error("channel low mark above high mark");

   // The shared divider is never restarted mid-division
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // PID completes before the result step
   a_pid_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && $past(state_ff == ST_PWAIT) |-> $past(pid_done))
      else $error("result step entered without PID completion");
endmodule
`default_nettype wire

### tb/lpps_tb_if.sv
// Testbench copy of nothing: the channel interfaces live in hw/rtl/lpps_if.sv.
// This file holds the shared testbench scan and item types. Depends on lpps_pkg.
`timescale 1ns / 1ps
package lpps_tb_pkg;
   import lpps_pkg::*;

   typedef logic [SAMPLE_W-1:0] scan_type [SENSOR_COUNT];

   typedef struct packed {
      logic signed [POS_W-1:0] line_position;
      logic [SPEED_W-1:0]      left_speed;
      logic [SPEED_W-1:0]      right_speed;
   } steer_type;
endpackage

### tb/lpps_checker.sv
// Steering checker: watches the scan, result and register channels, predicts each
// result from its own copy of marks, PID state and gains. Depends on lpps_pkg, lpps_tb_pkg.
`timescale 1ns / 1ps
module lpps_checker (
   input  wire logic clock,
   input  wire logic reset,
   lpps_req_if.sink  req_mon,
   lpps_rsp_if.sink  rsp_mon,
   lpps_csr_if.sink  csr_mon,
   output int        fail_count,
   output int        pending_count,
   output int        steer_count
);
   import lpps_pkg::*;
   import lpps_tb_pkg::*;

   logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
   logic [SPEED_W-1:0] base_q;
   logic [SAMPLE_W-1:0] mark_low [SENSOR_COUNT];
   logic [SAMPLE_W-1:0] mark_high [SENSOR_COUNT];
   longint last_error, integ;
   steer_type expected_steer [$];

   function automatic longint duty_of(input longint v);
      longint top;
      top = longint'(DUTY_MAX) <<< GAIN_FRAC_BITS;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v >>> GAIN_FRAC_BITS;
   endfunction

   // Advance the predictor by one scan and return the expected steering item
   function automatic steer_type steer_for(input scan_type scan);
      longint wsum, total, cal, pos, sum, dd, s, base, wt;
      steer_type st;
      wsum = 0;
      total = 0;
      pos = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (scan[i] < mark_low[i]) mark_low[i] = scan[i];
         if (scan[i] > mark_high[i]) mark_high[i] = scan[i];
         cal = 0;
         if (mark_high[i] > mark_low[i]) begin
            cal = (longint'(scan[i]) - longint'(mark_low[i])) * CAL_SCALE
                  / (longint'(mark_high[i]) - longint'(mark_low[i]));
            if (cal < 0) cal = 0;
            if (cal > CAL_SCALE) cal = CAL_SCALE;
         end
         wt = (longint'(2 * i - (SENSOR_COUNT - 1)) * WEIGHT_PITCH) / 2;
         wsum += cal * wt;
         total += cal;
      end
      if (total > 0) pos = wsum / total;
      if (pos < -4096) pos = -4096;
      if (pos > 4095) pos = 4095;
      sum = integ + pos;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      integ = sum;
      dd = pos - last_error;
      last_error = pos;
      s = longint'(kp_q) * pos + longint'(ki_q) * integ + longint'(kd_q) * dd;
      base = longint'(base_q) <<< GAIN_FRAC_BITS;
      st.line_position = POS_W'(pos);
      st.left_speed = SPEED_W'(duty_of(base - s));
      st.right_speed = SPEED_W'(duty_of(base + s));
      return st;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_steer.size();

   always @(posedge clock) begin
      scan_type scan;
      steer_type want;
      if (reset) begin
         kp_q <= KP_RESET;
         ki_q <= KI_RESET;
         kd_q <= KD_RESET;
         base_q <= BASE_RESET;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            mark_low[i] = RESET_LOW;
            mark_high[i] = RESET_HIGH;
         end
         last_error = 0;
         integ = 0;
         expected_steer.delete();
      end else begin
         // Track register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               REG_KP:   kp_q <= GAIN_W'(csr_mon.wr_data);
               REG_KI:   ki_q <= GAIN_W'(csr_mon.wr_data);
               REG_KD:   kd_q <= GAIN_W'(csr_mon.wr_data);
               REG_BASE: base_q <= SPEED_W'(csr_mon.wr_data);
               default: ;
            endcase
         end
         // Predict on each accepted scan
         if (req_mon.valid && req_mon.ready) begin
            scan[0] = req_mon.sample_0;
            scan[1] = req_mon.sample_1;
            scan[2] = req_mon.sample_2;
            scan[3] = req_mon.sample_3;
            scan[4] = req_mon.sample_4;
            scan[5] = req_mon.sample_5;
            scan[6] = req_mon.sample_6;
            scan[7] = req_mon.sample_7;
            expected_steer.push_back(steer_for(scan));
         end
         // Compare each accepted result with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            steer_count++;
            if (expected_steer.size() == 0) begin
               report_mismatch("unexpected result, position", rsp_mon.line_position, 0);
            end else begin
               want = expected_steer.pop_front();
               if (rsp_mon.line_position !== want.line_position)
                  report_mismatch("line_position", rsp_mon.line_position,
                                  want.line_position);
               if (rsp_mon.left_speed !== want.left_speed)
                  report_mismatch("left_speed", rsp_mon.left_speed, want.left_speed);
               if (rsp_mon.right_speed !== want.right_speed)
                  report_mismatch("right_speed", rsp_mon.right_speed, want.right_speed);
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      steer_count = 0;
   end
endmodule

### tb/tb.sv
// Top of the steering testbench: clock, reset, scan and register stimulus, verdict.
// Depends on lpps_pkg, lpps_tb_pkg, the RTL interfaces and lpps_checker.
`timescale 1ns / 1ps
module tb;
   import lpps_pkg::*;
   import lpps_tb_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   logic clock;
   logic reset;
   int   send_idle, take_idle;
   int   fail_count, pending_count, steer_count;
   int   quiet_cycles, scans_sent;

   lpps_req_if req_ch();
   lpps_rsp_if rsp_ch();
   lpps_csr_if csr_ch();

   line_position_pid_steering i_dut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   lpps_checker i_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_ch), .rsp_mon(rsp_ch), .csr_mon(csr_ch),
      .fail_count(fail_count), .pending_count(pending_count),
      .steer_count(steer_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stall, redrawn every cycle
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= take_idle);
   end

   // Watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_count);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_gains(input int kp, input int ki, input int kd, input int base);
      write_reg(REG_KP, kp);
      write_reg(REG_KI, ki);
      write_reg(REG_KD, kd);
      write_reg(REG_BASE, base);
   endtask

   // Drive one scan and hold it until accepted, then maybe idle
   task automatic send_scan(input scan_type scan);
      req_ch.valid <= 1'b1;
      req_ch.sample_0 <= scan[0];
      req_ch.sample_1 <= scan[1];
      req_ch.sample_2 <= scan[2];
      req_ch.sample_3 <= scan[3];
      req_ch.sample_4 <= scan[4];
      req_ch.sample_5 <= scan[5];
      req_ch.sample_6 <= scan[6];
      req_ch.sample_7 <= scan[7];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      scans_sent++;
      if ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_fill(input int value);
      scan_type scan;
      foreach (scan[i]) scan[i] = SAMPLE_W'(value);
      send_scan(scan);
   endtask

   // Random scan: mostly a line under one or two sensors, read high over a low floor
   task automatic send_random_scan();
      scan_type scan;
      int center, style;
      style = $urandom_range(9);
      center = $urandom_range(SENSOR_COUNT - 1);
      foreach (scan[i]) begin
         if (style == 0)
            scan[i] = SAMPLE_W'($urandom);
         else if (style == 1)
            scan[i] = $urandom_range(1) ? SAMPLE_W'(4095) : SAMPLE_W'(0);
         else if (i == center || (style > 6 && i == center + 1))
            scan[i] = SAMPLE_W'($urandom_range(3000, 4095));
         else
            scan[i] = SAMPLE_W'($urandom_range(0, 1500));
      end
      send_scan(scan);
   endtask

   // Close a phase: drain results, let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      scan_type scan;
      send_idle = 0;
      take_idle = 0;
      scans_sent = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.sample_0 = '0;
      req_ch.sample_1 = '0;
      req_ch.sample_2 = '0;
      req_ch.sample_3 = '0;
      req_ch.sample_4 = '0;
      req_ch.sample_5 = '0;
      req_ch.sample_6 = '0;
      req_ch.sample_7 = '0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wr_data = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset gains, dark scan, extremes
      send_fill(4095);
      send_fill(2500);
      send_fill(0);
      send_fill(0);
      send_fill(4095);
      foreach (scan[i]) scan[i] = (i == 0) ? 12'hFFF : 12'h000;
      send_scan(scan);
      foreach (scan[i]) scan[i] = (i == SENSOR_COUNT - 1) ? 12'hFFF : 12'h000;
      send_scan(scan);
      foreach (scan[i]) scan[i] = (i % 2) ? 12'hAAA : 12'h555;
      send_scan(scan);
      drain();
      // Largest gains, integral pushed hard, base at both ends
      set_gains(4095, 4095, 4095, 255);
      for (int k = 0; k < 6; k++) begin
         foreach (scan[i]) scan[i] = (i == 0) ? 12'hFFF : 12'h000;
         send_scan(scan);
      end
      foreach (scan[i]) scan[i] = (i == SENSOR_COUNT - 1) ? 12'hFFF : 12'h000;
      send_scan(scan);
      drain();
      set_gains(0, 0, 0, 0);
      send_fill(1234);
      send_random_scan();
      drain();

      // Random phases across idling patterns and gain settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 3)
            0: begin send_idle = 6;  take_idle = 57; end
            1: begin send_idle = 57; take_idle = 6;  end
            default: begin send_idle = 0; take_idle = 0; end
         endcase
         if (phase == 7)
            set_gains(4095, 4095, 4095, 255);
         else
            set_gains($urandom_range(4095), $urandom_range(0, 40),
                      $urandom_range(4095), $urandom_range(255));
         write_reg(REG_KI, $urandom_range(1) ? 0 : $urandom_range(4095));
         repeat (100) send_random_scan();
         drain();
      end

      $display("Sent %0d scans, checked %0d results over eight gain settings",
               scans_sent, steer_count);
      $display("and three idling patterns, with reset and extreme gains included.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
